@@ hdl/stereo_center_confidence_tracker_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the stereo center confidence tracker.
// Each macro expands to a concurrent assertion in simulation and to nothing
// in synthesis.
// ----------------------------------------------------------------------------
`ifndef STEREO_CENTER_CONFIDENCE_TRACKER_CORE_ASSERT_SVH
`define STEREO_CENTER_CONFIDENCE_TRACKER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define SCCT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define SCCT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) ante |=> cons) else $error(msg);
`else
`define SCCT_ASSERT(label, prop, msg)
`define SCCT_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

@@ hdl/scct_pkg.sv @@
// ----------------------------------------------------------------------------
// Stereo center confidence tracker package
// Payload types, unit status type, fixed-point constants and small helpers.
// ----------------------------------------------------------------------------
package scct_pkg;

   localparam int SAMPLE_W = 24;
   localparam int SUM_W    = 60;

   typedef struct packed {
      logic signed [23:0] left_sample;
      logic signed [23:0] right_sample;
      logic               last_of_block;
   } req_payload_type;

   typedef struct packed {
      logic [16:0]        center_focus;
      logic [16:0]        previous_focus;
      logic signed [15:0] coherence_value;
   } rsp_payload_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

   localparam logic [16:0] Q_ONE         = 17'd65536;
   localparam logic [17:0] Q_QUARTER     = 18'd16384;
   localparam logic [16:0] Q_CORR_GAIN   = 17'd52429;
   localparam logic [17:0] Q_WIDTH_BASE  = 18'd68813;
   localparam logic [15:0] Q_WIDTH_SLOPE = 16'd40632;
   localparam logic [16:0] Q_FLOOR       = 17'd11796;
   localparam logic [16:0] Q_FOCUS_INIT  = 17'd45875;
   localparam logic [16:0] Q_SMOOTH_INIT = 17'd11796;
   localparam logic [17:0] RATIO_MAX     = 18'd131072;
   localparam logic [15:0] COH_FULL      = 16'h8000;
   localparam logic [18:0] ROUND_HALF    = 19'd32768;
   localparam logic [17:0] WIDTH_TOP_LIM = 18'd3277;
   localparam logic [17:0] WIDTH_BOT_LIM = 18'd57017;

   localparam logic [5:0] SAMPLE_MUL_LAST = 6'd24;
   localparam logic [5:0] SUM_MUL_LAST    = 6'd59;
   localparam logic [5:0] SQRT_LAST       = 6'd59;
   localparam logic [5:0] COH_FRAC_BITS   = 6'd15;
   localparam logic [5:0] RATIO_FRAC_BITS = 6'd34;

   function automatic logic [24:0] abs25(input logic [24:0] v);
      return v[24] ? (~v + 25'd1) : v;
   endfunction

   function automatic logic [59:0] sat_add60(input logic [59:0] s, input logic [49:0] p);
      logic [60:0] t;
      t = {1'b0, s} + {11'd0, p};
      return t[60] ? {60{1'b1}} : t[59:0];
   endfunction

   function automatic logic [15:0] coh_of(input logic neg, input logic [15:0] q);
      if (neg) begin
         return ~q + 16'd1;
      end
      return q[15] ? 16'h7FFF : q;
   endfunction

endpackage

@@ hdl/scct_isqrt.sv @@
// ----------------------------------------------------------------------------
// Serial integer square root
// Floor square root of a 120-bit radicand, one result bit per cycle.
// ----------------------------------------------------------------------------
module scct_isqrt
   import scct_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [119:0]    radicand,
   output unit_status_type status,
   output logic [59:0]     root
);

   logic [119:0] rad_ff, rad_in;
   logic [61:0]  rem_ff, rem_in;
   logic [59:0]  root_ff, root_in;
   logic [5:0]   iter_ff, iter_in;
   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [63:0]  rem_sh;
   logic [63:0]  trial;
   logic [63:0]  rem_nx;
   logic         ge;

   always_comb begin
      rem_sh  = {rem_ff, rad_ff[119:118]};
      trial   = {2'b00, root_ff, 2'b01};
      ge      = rem_sh >= trial;
      rem_nx  = ge ? (rem_sh - trial) : rem_sh;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      iter_in = iter_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         iter_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[117:0], 2'b00};
         rem_in  = rem_nx[61:0];
         root_in = {root_ff[58:0], ge};
         iter_in = iter_ff + 6'd1;
         if (iter_ff == SQRT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      iter_ff <= iter_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign root        = root_ff;

endmodule

@@ hdl/scct_fdiv.sv @@
// ----------------------------------------------------------------------------
// Serial fractional divider
// Restoring division giving floor(num * 2^steps / den) for num below den,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module scct_fdiv
   import scct_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [59:0]     num,
   input  logic [61:0]     den,
   input  logic [5:0]      steps,
   output unit_status_type status,
   output logic [33:0]     quot
);

   logic [61:0] rem_ff, rem_in;
   logic [61:0] den_ff, den_in;
   logic [33:0] quot_ff, quot_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [62:0] rem_sh;
   logic [62:0] rem_nx;
   logic        ge;

   always_comb begin
      rem_sh  = {rem_ff, 1'b0};
      ge      = rem_sh >= {1'b0, den_ff};
      rem_nx  = ge ? (rem_sh - {1'b0, den_ff}) : rem_sh;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = {2'b00, num};
         den_in  = den;
         quot_in = '0;
         cnt_in  = steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = rem_nx[61:0];
         quot_in = {quot_ff[32:0], ge};
         cnt_in  = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quot        = quot_ff;

endmodule

@@ hdl/stereo_center_confidence_tracker_core.sv @@
// ----------------------------------------------------------------------------
// Stereo center confidence tracker
// Accumulates stereo energies over blocks and tracks a smoothed center focus.
// ----------------------------------------------------------------------------
// The req channel carries one stereo sample per transaction; the sample that
// ends an analysis block has last_of_block set. The rsp channel carries one
// transaction per block: the new focus, the focus before the block and the
// coherence. The csr port writes the smoothing factor and must only be used
// while the block is idle.
// Each sample passes through five bit-serial multipliers, and the block takes
// no new sample until it has finished with the last one. The last sample of a
// block adds a serial 60 x 60 multiply, one or two serial square roots and up
// to two serial divisions before the result is registered on rsp.
// A block longer than MAX_BLOCK_LEN samples gives no result and is dropped.
// The result sits in an output register; the next samples are accepted while
// the receiver stalls, and only a second finished result waits for it.
// Reset clears all sums, sets the focus to 0.70 and the smoothing factor to
// 0.18, and empties the output register.
// ----------------------------------------------------------------------------
`include "stereo_center_confidence_tracker_core_assert.svh"

module stereo_center_confidence_tracker_core
   import scct_pkg::*;
#(
   parameter int MAX_BLOCK_LEN = 4096
)
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data,
   input  logic            csr_write_enable,
   input  logic [16:0]     csr_write_data
);

   localparam int CNT_W = $clog2(MAX_BLOCK_LEN + 2);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BLOCK_LEN);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_MUL       = 4'd1;
   localparam logic [3:0] S_ACC       = 4'd2;
   localparam logic [3:0] S_BMUL      = 4'd3;
   localparam logic [3:0] S_SQ1_GO    = 4'd4;
   localparam logic [3:0] S_SQ1_WAIT  = 4'd5;
   localparam logic [3:0] S_DIV1_GO   = 4'd6;
   localparam logic [3:0] S_DIV1_WAIT = 4'd7;
   localparam logic [3:0] S_DIV2_GO   = 4'd8;
   localparam logic [3:0] S_DIV2_WAIT = 4'd9;
   localparam logic [3:0] S_SQ2_GO    = 4'd10;
   localparam logic [3:0] S_SQ2_WAIT  = 4'd11;
   localparam logic [3:0] S_CALC1     = 4'd12;
   localparam logic [3:0] S_CALC2     = 4'd13;
   localparam logic [3:0] S_CALC3     = 4'd14;

   logic [3:0]             state_ff, state_in;
   logic [5:0]             step_ff, step_in;
   logic [4:0][24:0]       opa_ff, opa_in;
   logic [4:0][49:0]       prod_ff, prod_in;
   logic                   cneg_ff, cneg_in;
   logic                   last_ff, last_in;
   logic [59:0]            cross_ff, cross_in;
   logic [59:0]            lsum_ff, lsum_in;
   logic [59:0]            rsum_ff, rsum_in;
   logic [59:0]            msum_ff, msum_in;
   logic [59:0]            ssum_ff, ssum_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [119:0]           big_ff, big_in;
   logic [59:0]            root_ff, root_in;
   logic [15:0]            coh_ff, coh_in;
   logic [17:0]            ratio_ff, ratio_in;
   logic [16:0]            corr_ff, corr_in;
   logic [16:0]            width_ff, width_in;
   logic [16:0]            target_ff, target_in;
   logic [16:0]            focus_ff, focus_in;
   logic [16:0]            smooth_ff, smooth_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_data_ff, rsp_data_in;

   logic [24:0]            l_ext, r_ext, sum_ext, dif_ext;
   logic [24:0]            l_mag, r_mag, sum_mag, dif_mag;
   logic [4:0][25:0]       lane_sum;
   logic [60:0]            cross_delta, cross_wide;
   logic [59:0]            cross_new, lsum_new, rsum_new, msum_new, ssum_new;
   logic [59:0]            cross_mag;
   logic [60:0]            big_sum;
   logic                   ratio_sat;
   logic                   out_free;
   logic [17:0]            t_val;
   logic [33:0]            corr_prod, width_prod, target_prod, step_prod;
   logic [18:0]            corr_rnd, width_rnd, target_rnd, step_rnd;
   logic [16:0]            k_val, d_mag;
   logic [18:0]            focus_up;
   logic [16:0]            focus_new;

   logic                   sq_start, dv_start;
   logic [119:0]           sq_radicand;
   unit_status_type        sq_status, dv_status;
   logic [59:0]            sq_root;
   logic [59:0]            dv_num;
   logic [61:0]            dv_den;
   logic [5:0]             dv_steps;
   logic [33:0]            dv_quot;

   scct_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sq_radicand),
      .status   (sq_status),
      .root     (sq_root)
   );

   scct_fdiv u_fdiv (
      .clock  (clock),
      .reset  (reset),
      .start  (dv_start),
      .num    (dv_num),
      .den    (dv_den),
      .steps  (dv_steps),
      .status (dv_status),
      .quot   (dv_quot)
   );

   always_comb begin
      l_ext   = {req_data.left_sample[23], req_data.left_sample};
      r_ext   = {req_data.right_sample[23], req_data.right_sample};
      sum_ext = l_ext + r_ext;
      dif_ext = l_ext - r_ext;
      l_mag   = abs25(l_ext);
      r_mag   = abs25(r_ext);
      sum_mag = abs25(sum_ext);
      dif_mag = abs25(dif_ext);

      for (int i = 0; i < 5; i++) begin
         lane_sum[i] = {1'b0, prod_ff[i][49:25]} +
                       (prod_ff[i][0] ? {1'b0, opa_ff[i]} : 26'd0);
      end

      cross_delta = cneg_ff ? (~{11'd0, prod_ff[0]} + 61'd1) : {11'd0, prod_ff[0]};
      cross_wide  = {cross_ff[59], cross_ff} + cross_delta;
      if (cross_wide[60] != cross_wide[59]) begin
         cross_new = cross_wide[60] ? {1'b1, 59'd0} : {1'b0, {59{1'b1}}};
      end else begin
         cross_new = cross_wide[59:0];
      end
      lsum_new = sat_add60(lsum_ff, prod_ff[1]);
      rsum_new = sat_add60(rsum_ff, prod_ff[2]);
      msum_new = sat_add60(msum_ff, {2'b00, prod_ff[3][49:2]});
      ssum_new = sat_add60(ssum_ff, {2'b00, prod_ff[4][49:2]});

      cross_mag = cross_ff[59] ? (~cross_ff + 60'd1) : cross_ff;
      big_sum   = {1'b0, big_ff[119:60]} + (big_ff[0] ? {1'b0, lsum_ff} : 61'd0);
      ratio_sat = (msum_ff == '0) || ({2'b00, ssum_ff} >= {msum_ff, 2'b00});
      out_free  = !rsp_valid_ff || !rsp_stall;

      t_val      = {coh_ff[15], coh_ff, 1'b0} + Q_QUARTER;
      corr_prod  = t_val[16:0] * Q_CORR_GAIN;
      corr_rnd   = 19'({1'b0, corr_prod} + 35'd32768 >> 16);
      width_prod = Q_WIDTH_SLOPE * ratio_ff;
      width_rnd  = 19'({1'b0, width_prod} + 35'd32768 >> 16);
      target_prod = corr_ff * width_ff;
      target_rnd  = 19'({1'b0, target_prod} + 35'd32768 >> 16);
      k_val     = (smooth_ff > Q_ONE) ? Q_ONE : smooth_ff;
      d_mag     = (target_ff >= focus_ff) ? (target_ff - focus_ff) : (focus_ff - target_ff);
      step_prod = d_mag * k_val;
      step_rnd  = 19'({1'b0, step_prod} + 35'd32768 >> 16);
      if (target_ff >= focus_ff) begin
         focus_up  = {2'b00, focus_ff} + step_rnd;
         focus_new = (focus_up > {2'b00, Q_ONE}) ? Q_ONE : focus_up[16:0];
      end else begin
         focus_up  = '0;
         focus_new = ({2'b00, focus_ff} < step_rnd) ? 17'd0 : (focus_ff - step_rnd[16:0]);
      end

      sq_start    = (state_ff == S_SQ1_GO) || (state_ff == S_SQ2_GO);
      sq_radicand = (state_ff == S_SQ2_GO) ? {86'd0, dv_quot} : big_ff;
      dv_start    = ((state_ff == S_DIV1_GO) && (root_ff != '0) && (cross_mag < root_ff)) ||
                    ((state_ff == S_DIV2_GO) && !ratio_sat);
      if (state_ff == S_DIV2_GO) begin
         dv_num   = ssum_ff;
         dv_den   = {msum_ff, 2'b00};
         dv_steps = RATIO_FRAC_BITS;
      end else begin
         dv_num   = cross_mag;
         dv_den   = {2'b00, root_ff};
         dv_steps = COH_FRAC_BITS;
      end

      state_in     = state_ff;
      step_in      = step_ff;
      opa_in       = opa_ff;
      prod_in      = prod_ff;
      cneg_in      = cneg_ff;
      last_in      = last_ff;
      cross_in     = cross_ff;
      lsum_in      = lsum_ff;
      rsum_in      = rsum_ff;
      msum_in      = msum_ff;
      ssum_in      = ssum_ff;
      cnt_in       = cnt_ff;
      big_in       = big_ff;
      root_in      = root_ff;
      coh_in       = coh_ff;
      ratio_in     = ratio_ff;
      corr_in      = corr_ff;
      width_in     = width_ff;
      target_in    = target_ff;
      focus_in     = focus_ff;
      smooth_in    = csr_write_enable ? csr_write_data : smooth_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               opa_in[0]  = l_mag;
               prod_in[0] = {25'd0, r_mag};
               opa_in[1]  = l_mag;
               prod_in[1] = {25'd0, l_mag};
               opa_in[2]  = r_mag;
               prod_in[2] = {25'd0, r_mag};
               opa_in[3]  = sum_mag;
               prod_in[3] = {25'd0, sum_mag};
               opa_in[4]  = dif_mag;
               prod_in[4] = {25'd0, dif_mag};
               cneg_in    = req_data.left_sample[23] ^ req_data.right_sample[23];
               last_in    = req_data.last_of_block;
               step_in    = '0;
               state_in   = S_MUL;
            end
         end
         S_MUL: begin
            for (int i = 0; i < 5; i++) begin
               prod_in[i] = {lane_sum[i], prod_ff[i][24:1]};
            end
            step_in = step_ff + 6'd1;
            if (step_ff == SAMPLE_MUL_LAST) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            cross_in = cross_new;
            lsum_in  = lsum_new;
            rsum_in  = rsum_new;
            msum_in  = msum_new;
            ssum_in  = ssum_new;
            if (cnt_ff <= MAX_CNT) begin
               cnt_in = cnt_ff + 1'b1;
            end
            big_in  = {60'd0, rsum_new};
            step_in = '0;
            if (!last_ff) begin
               state_in = S_IDLE;
            end else if (cnt_ff >= MAX_CNT) begin
               cross_in = '0;
               lsum_in  = '0;
               rsum_in  = '0;
               msum_in  = '0;
               ssum_in  = '0;
               cnt_in   = '0;
               state_in = S_IDLE;
            end else begin
               state_in = S_BMUL;
            end
         end
         S_BMUL: begin
            big_in  = {big_sum, big_ff[59:1]};
            step_in = step_ff + 6'd1;
            if (step_ff == SUM_MUL_LAST) begin
               state_in = S_SQ1_GO;
            end
         end
         S_SQ1_GO: begin
            state_in = S_SQ1_WAIT;
         end
         S_SQ1_WAIT: begin
            if (sq_status.done) begin
               root_in  = sq_root;
               state_in = S_DIV1_GO;
            end
         end
         S_DIV1_GO: begin
            if (root_ff == '0) begin
               coh_in   = '0;
               state_in = S_DIV2_GO;
            end else if (cross_mag >= root_ff) begin
               coh_in   = coh_of(cross_ff[59], COH_FULL);
               state_in = S_DIV2_GO;
            end else begin
               state_in = S_DIV1_WAIT;
            end
         end
         S_DIV1_WAIT: begin
            if (dv_status.done) begin
               coh_in   = coh_of(cross_ff[59], dv_quot[15:0]);
               state_in = S_DIV2_GO;
            end
         end
         S_DIV2_GO: begin
            if (ratio_sat) begin
               ratio_in = RATIO_MAX;
               state_in = S_CALC1;
            end else begin
               state_in = S_DIV2_WAIT;
            end
         end
         S_DIV2_WAIT: begin
            if (dv_status.done) begin
               state_in = S_SQ2_GO;
            end
         end
         S_SQ2_GO: begin
            state_in = S_SQ2_WAIT;
         end
         S_SQ2_WAIT: begin
            if (sq_status.done) begin
               ratio_in = sq_root[17:0];
               state_in = S_CALC1;
            end
         end
         S_CALC1: begin
            if (t_val[17] || (t_val == '0)) begin
               corr_in = '0;
            end else if (corr_rnd > {2'b00, Q_ONE}) begin
               corr_in = Q_ONE;
            end else begin
               corr_in = corr_rnd[16:0];
            end
            if (width_rnd <= {1'b0, WIDTH_TOP_LIM}) begin
               width_in = Q_ONE;
            end else if (width_rnd >= {1'b0, WIDTH_BOT_LIM}) begin
               width_in = Q_FLOOR;
            end else begin
               width_in = 17'(Q_WIDTH_BASE - width_rnd[17:0]);
            end
            state_in = S_CALC2;
         end
         S_CALC2: begin
            if (target_rnd < {2'b00, Q_FLOOR}) begin
               target_in = Q_FLOOR;
            end else if (target_rnd > {2'b00, Q_ONE}) begin
               target_in = Q_ONE;
            end else begin
               target_in = target_rnd[16:0];
            end
            state_in = S_CALC3;
         end
         S_CALC3: begin
            if (out_free) begin
               focus_in                    = focus_new;
               rsp_valid_in                = 1'b1;
               rsp_data_in.center_focus    = focus_new;
               rsp_data_in.previous_focus  = focus_ff;
               rsp_data_in.coherence_value = coh_ff;
               cross_in = '0;
               lsum_in  = '0;
               rsum_in  = '0;
               msum_in  = '0;
               ssum_in  = '0;
               cnt_in   = '0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      opa_ff      <= opa_in;
      prod_ff     <= prod_in;
      cneg_ff     <= cneg_in;
      last_ff     <= last_in;
      big_ff      <= big_in;
      root_ff     <= root_in;
      coh_ff      <= coh_in;
      ratio_ff    <= ratio_in;
      corr_ff     <= corr_in;
      width_ff    <= width_in;
      target_ff   <= target_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         cross_ff     <= '0;
         lsum_ff      <= '0;
         rsum_ff      <= '0;
         msum_ff      <= '0;
         ssum_ff      <= '0;
         cnt_ff       <= '0;
         focus_ff     <= Q_FOCUS_INIT;
         smooth_ff    <= Q_SMOOTH_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cross_ff     <= cross_in;
         lsum_ff      <= lsum_in;
         rsum_ff      <= rsum_in;
         msum_ff      <= msum_in;
         ssum_ff      <= ssum_in;
         cnt_ff       <= cnt_in;
         focus_ff     <= focus_in;
         smooth_ff    <= smooth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SCCT_ASSERT(a_focus_range, focus_ff <= Q_ONE, "Focus left its range.")
   `SCCT_ASSERT(a_rsp_from_calc, $rose(rsp_valid_ff) |-> ($past(state_ff) == S_CALC3), "Result appeared outside the final step.")
   `SCCT_ASSERT_NEXT(a_prev_focus, (state_ff == S_CALC3) && out_free, rsp_data_ff.previous_focus == $past(focus_ff), "Previous focus does not match.")
   `SCCT_ASSERT(a_sums_clear, (cnt_ff == '0) |-> ((lsum_ff == '0) && (cross_ff == '0)), "Sums not cleared with the block count.")

endmodule

@@ dv/tb_stereo_center_confidence_tracker_core.sv @@
// ----------------------------------------------------------------------------
// Testbench for the stereo center confidence tracker
// Drives stereo sample blocks with bursty valid and a randomly stalling
// receiver, predicts every block result with a bit-exact model of the
// energy sums, coherence, width ratio and focus smoothing, and checks each
// rsp transaction field by field. The smoothing factor is rewritten between
// phases, including its extremes and a value above 1.0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_stereo_center_confidence_tracker_core;
   import scct_pkg::*;

   localparam int     BLOCK_LIMIT = 4096;
   localparam longint ONE         = longint'(Q_ONE);
   localparam longint FLOOR_W     = longint'(Q_FLOOR);
   localparam longint SUM_TOP     = (64'd1 << 60) - 1;
   localparam longint CROSS_TOP   = (64'sd1 <<< 59) - 1;
   localparam logic signed [23:0] S_MAX = 24'sh7FFFFF;
   localparam logic signed [23:0] S_MIN = -24'sh800000;

   typedef struct {
      logic signed [23:0] left;
      logic signed [23:0] right;
      bit                 last;
      bit                 typed;
      rsp_payload_type    result;
   } sample_row_type;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_data;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_data;
   logic            csr_write_enable;
   logic [16:0]     csr_write_data;

   longint          cross_sum;
   logic [63:0]     left_sum, right_sum, mid_sum, side_sum;
   longint          focus, smoothing;
   int              sample_count;
   rsp_payload_type focus_results[$];
   int              errors = 0;
   int              burst_left;
   int              stall_mode = 0;
   int              stall_left = 0;
   int              stall_phase = 0;

   sample_row_type directed_rows[14] = '{
      '{24'sd0, 24'sd0, 1'b1, 1'b1, '{17'd39741, 17'd45875, 16'sd0}},
      '{S_MAX, S_MAX, 1'b1, 1'b0, '0},
      '{S_MIN, S_MIN, 1'b1, 1'b0, '0},
      '{S_MAX, S_MIN, 1'b1, 1'b0, '0},
      '{S_MAX, 24'sd0, 1'b1, 1'b0, '0},
      '{24'sd0, S_MIN, 1'b1, 1'b0, '0},
      '{24'sd1000, -24'sd1000, 1'b0, 1'b0, '0},
      '{-24'sd5, 24'sd5, 1'b1, 1'b0, '0},
      '{24'sd12345, 24'sd12000, 1'b0, 1'b0, '0},
      '{-24'sd300000, -24'sd290000, 1'b0, 1'b0, '0},
      '{24'sd7000000, 24'sd6500000, 1'b1, 1'b0, '0},
      '{24'sd1, -24'sd1, 1'b1, 1'b0, '0},
      '{24'sd4000000, -24'sd100, 1'b0, 1'b0, '0},
      '{24'sd2, 24'sd3, 1'b1, 1'b0, '0}
   };

   stereo_center_confidence_tracker_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [63:0] floor_sqrt(input logic [127:0] v);
      logic [127:0] rem, root, trial;
      rem  = '0;
      root = '0;
      for (int i = 59; i >= 0; i--) begin
         rem   = (rem << 2) | v[2*i +: 2];
         trial = (root << 2) | 1;
         if (rem >= trial) begin
            rem  = rem - trial;
            root = (root << 1) | 1;
         end else begin
            root = root << 1;
         end
      end
      return root[63:0];
   endfunction

   function automatic logic [63:0] add_energy(input logic [63:0] s, input logic [63:0] p);
      logic [63:0] t;
      t = s + p;
      return (t > SUM_TOP) ? SUM_TOP : t;
   endfunction

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic void clear_energies();
      cross_sum    = 0;
      left_sum     = '0;
      right_sum    = '0;
      mid_sum      = '0;
      side_sum     = '0;
      sample_count = 0;
   endfunction

   // Returns 1 and the block result when the sample closes a valid block.
   function automatic bit track_focus(input req_payload_type p, output rsp_payload_type r);
      longint      l, r_s, sum, dif, coh, t, corr_w, width_w, target, d, prev, k, step;
      logic [63:0] root, mag, q, ratio;
      logic [127:0] prod;
      bit          neg;
      l   = longint'(p.left_sample);
      r_s = longint'(p.right_sample);
      sum = l + r_s;
      dif = l - r_s;
      cross_sum = clamp(cross_sum + l * r_s, -CROSS_TOP - 1, CROSS_TOP);
      left_sum  = add_energy(left_sum, l * l);
      right_sum = add_energy(right_sum, r_s * r_s);
      mid_sum   = add_energy(mid_sum, (sum * sum) >> 2);
      side_sum  = add_energy(side_sum, (dif * dif) >> 2);
      if (sample_count <= BLOCK_LIMIT) sample_count++;
      r = '0;
      if (!p.last_of_block) return 1'b0;
      if (sample_count > BLOCK_LIMIT) begin
         clear_energies();
         return 1'b0;
      end
      prod = 128'(left_sum) * 128'(right_sum);
      root = floor_sqrt(prod);
      neg  = cross_sum < 0;
      mag  = neg ? -cross_sum : cross_sum;
      if (root == 0) begin
         coh = 0;
      end else begin
         q   = (mag >= root) ? 64'd32768 : 64'((128'(mag) << 15) / 128'(root));
         coh = neg ? -longint'(q) : ((q > 32767) ? 32767 : longint'(q));
      end
      if (mid_sum == 0 || side_sum >= 4 * mid_sum) begin
         ratio = 64'd131072;
      end else begin
         ratio = floor_sqrt((128'(side_sum) << 32) / 128'(mid_sum));
      end
      t       = 2 * coh + longint'(Q_QUARTER);
      corr_w  = (t <= 0) ? 0 : clamp((t * longint'(Q_CORR_GAIN) + 32768) >>> 16, 0, ONE);
      width_w = longint'(Q_WIDTH_BASE) - ((longint'(Q_WIDTH_SLOPE) * longint'(ratio) + 32768) >>> 16);
      width_w = clamp(width_w, FLOOR_W, ONE);
      target  = clamp((corr_w * width_w + 32768) >>> 16, FLOOR_W, ONE);
      k       = (smoothing > ONE) ? ONE : smoothing;
      prev    = focus;
      d       = target - prev;
      step    = (((d < 0) ? -d : d) * k + 32768) >>> 16;
      focus   = clamp((d < 0) ? prev - step : prev + step, 0, ONE);
      r.center_focus    = focus[16:0];
      r.previous_focus  = prev[16:0];
      r.coherence_value = coh[15:0];
      clear_energies();
      return 1'b1;
   endfunction

   task automatic send_sample(input req_payload_type p, input bit typed, input rsp_payload_type t);
      rsp_payload_type r;
      int              gap;
      req_valid <= 1'b1;
      req_data  <= p;
      do @(posedge clock); while (req_stall);
      if (track_focus(p, r)) focus_results.push_back(typed ? t : r);
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (focus_results.size() > 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_smoothing(input logic [16:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      smoothing = longint'(value);
   endtask

   function automatic logic signed [23:0] pick_extreme();
      case ($urandom_range(0, 3))
         0: return S_MAX;
         1: return S_MIN;
         2: return 24'sd0;
         default: return -24'sd1;
      endcase
   endfunction

   task automatic random_blocks(input int items);
      req_payload_type p;
      int              sent, len, mode;
      longint          v;
      sent = 0;
      while (sent < items) begin
         len  = ($urandom_range(0, 19) == 0) ? $urandom_range(64, 300) : $urandom_range(1, 12);
         mode = $urandom_range(0, 5);
         for (int i = 0; i < len; i++) begin
            p.left_sample = 24'($urandom);
            case (mode)
               0: p.right_sample = 24'($urandom);
               1: begin
                  v = longint'(p.left_sample) + $signed($urandom_range(0, 20000)) - 10000;
                  p.right_sample = 24'(clamp(v, longint'(S_MIN), longint'(S_MAX)));
               end
               2: p.right_sample = 24'(clamp(-longint'(p.left_sample), longint'(S_MIN),
                                             longint'(S_MAX)));
               3: begin
                  p.left_sample  = 24'($signed($urandom_range(0, 127)) - 64);
                  p.right_sample = 24'($signed($urandom_range(0, 127)) - 64);
               end
               4: begin
                  p.right_sample = 24'sd0;
                  if ($urandom_range(0, 1)) begin
                     p.right_sample = p.left_sample;
                     p.left_sample  = 24'sd0;
                  end
               end
               default: begin
                  p.left_sample  = pick_extreme();
                  p.right_sample = pick_extreme();
               end
            endcase
            p.last_of_block = (i == len - 1);
            send_sample(p, 1'b0, '0);
         end
         sent += len;
      end
   endtask

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(20, 400);
      end
      stall_left--;
      stall_phase++;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 1) == 1);
         2: rsp_stall <= ($urandom_range(0, 7) != 0);
         default: rsp_stall <= (stall_phase % 16) < 12;
      endcase
   end

   always @(posedge clock) begin
      rsp_payload_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (focus_results.size() == 0) begin
            $display("%0t: unexpected transaction, actual %p", $time, rsp_data);
            errors++;
         end else begin
            e = focus_results.pop_front();
            if (rsp_data.center_focus !== e.center_focus) begin
               $display("%0t: center_focus expected %0d actual %0d", $time,
                        e.center_focus, rsp_data.center_focus);
               errors++;
            end
            if (rsp_data.previous_focus !== e.previous_focus) begin
               $display("%0t: previous_focus expected %0d actual %0d", $time,
                        e.previous_focus, rsp_data.previous_focus);
               errors++;
            end
            if (rsp_data.coherence_value !== e.coherence_value) begin
               $display("%0t: coherence_value expected %0d actual %0d", $time,
                        e.coherence_value, rsp_data.coherence_value);
               errors++;
            end
         end
      end
   end

   initial begin
      #20_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      req_payload_type p;
      burst_left       = 0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      clear_energies();
      focus     = longint'(Q_FOCUS_INIT);
      smoothing = longint'(Q_SMOOTH_INIT);
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         p.left_sample   = directed_rows[i].left;
         p.right_sample  = directed_rows[i].right;
         p.last_of_block = directed_rows[i].last;
         send_sample(p, directed_rows[i].typed, directed_rows[i].result);
      end
      wait_idle();

      write_smoothing(17'd0);
      random_blocks(150);
      wait_idle();
      write_smoothing(17'd65536);
      random_blocks(200);
      wait_idle();
      write_smoothing(17'h1FFFF);
      random_blocks(150);
      wait_idle();

      write_smoothing(Q_SMOOTH_INIT);
      random_blocks(20);
      wait_idle();

      for (int ph = 0; ph < 4; ph++) begin
         write_smoothing(17'($urandom_range(0, 65536)));
         random_blocks(220);
         wait_idle();
      end

      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ stereo_center_confidence_tracker_core.f @@
+incdir+hdl
hdl/scct_pkg.sv
hdl/scct_isqrt.sv
hdl/scct_fdiv.sv
hdl/stereo_center_confidence_tracker_core.sv
dv/tb_stereo_center_confidence_tracker_core.sv
